FILE: rtl/dpf_pkg.sv
package dpf_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned SRC_W  = 18;
  localparam int unsigned DST_W  = 18;
  localparam int unsigned TS_W   = 30;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned LIM_W  = 7;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_FWD   = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

  localparam logic [LIM_W-1:0] LIM_RESET = 7'd64;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SRC_W-1:0] source;
    logic [DST_W-1:0] destination;
    logic [TS_W-1:0]  timestamp;
    logic [TS_W-1:0]  start_time;
    logic [TS_W-1:0]  end_time;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [SRC_W-1:0] out_source;
    logic [DST_W-1:0] out_destination;
    logic [TS_W-1:0]  out_timestamp;
    logic [CNT_W-1:0] match_count;
  } res_t;

  typedef struct packed {
    logic [SRC_W-1:0] source;
    logic [DST_W-1:0] destination;
    logic [TS_W-1:0]  timestamp;
  } entry_t;

  typedef struct packed {
    logic rotate;
    logic shift;
    logic write;
    logic evict;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

endpackage

FILE: rtl/dedup_packet_fifo_with_range_count.sv
// add and count query with a non-empty fifo scan the stored packets in ST_SCAN and then pass
// ST_FINISH; forward, unused codes and an empty fifo go straight to ST_FINISH
// the strobe is registered out of ST_FINISH; a new start word is taken only in ST_IDLE;
// the stored packets rotate once through the cell row, one packet past the comparators a cycle
// reset: fifo empty, memory_limit 64, no strobe; the result strobe cannot be held off
module dedup_packet_fifo_with_range_count
  import dpf_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             done_o,
  output res_t             res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LIM_W-1:0] cfg_data_i
);

  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (FW > LIM_W) ? FW : LIM_W;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic [FW-1:0]    step_q, step_d;
  logic [FW-1:0]    cnt_q, cnt_d;
  logic             dup_q, dup_d;
  logic [LIM_W-1:0] lim_q;
  logic             done_q, done_d;
  res_t             res_q, res_d;

  logic [LW-1:0] lim_eff;
  logic          at_limit;
  cell_ctl_t     ctl;
  entry_t        new_entry;
  entry_t        cell_out [DEPTH];
  entry_t        head;

  assign head = cell_out[0];
  assign busy = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    lim_eff = LW'(lim_q);
    if (lim_q == '0) begin
      lim_eff = LW'(1);
    end else if (LW'(lim_q) > LW'(DEPTH)) begin
      lim_eff = LW'(DEPTH);
    end
  end

  assign at_limit = (LW'(fill_q) >= lim_eff);

  assign new_entry.source      = req_q.source;
  assign new_entry.destination = req_q.destination;
  assign new_entry.timestamp   = req_q.timestamp;

  always_comb begin
    ctl.rotate = (state_q == ST_SCAN);
    ctl.write  = (state_q == ST_FINISH) && (req_q.op == OP_ADD) && !dup_q;
    ctl.evict  = at_limit;
    ctl.shift  = (state_q == ST_FINISH) &&
                 (((req_q.op == OP_FWD) && (fill_q != '0)) || (ctl.write && at_limit));
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t next_e;
    if (i == DEPTH - 1) begin : g_end
      assign next_e = cell_out[i];
    end else begin : g_mid
      assign next_e = cell_out[i+1];
    end
    dpf_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .at_last_i (fill_q == FW'(i + 1)),
      .at_tail_i (fill_q == FW'(i)),
      .next_i    (next_e),
      .head_i    (head),
      .wr_i      (new_entry),
      .entry_o   (cell_out[i])
    );
  end

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    fill_d  = fill_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    dup_d   = dup_q;
    done_d  = 1'b0;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d  = req_i;
          step_d = '0;
          cnt_d  = '0;
          dup_d  = 1'b0;
          if (((req_i.op == OP_ADD) || (req_i.op == OP_COUNT)) && (fill_q != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (head.destination == req_q.destination) begin
          if ((head.source == req_q.source) && (head.timestamp == req_q.timestamp)) begin
            dup_d = 1'b1;
          end
          if ((head.timestamp >= req_q.start_time) && (head.timestamp <= req_q.end_time)) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        step_d = step_q + 1'b1;
        if (step_q == fill_q - 1'b1) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        done_d  = 1'b1;
        res_d   = '0;
        state_d = ST_IDLE;
        case (req_q.op)
          OP_ADD: begin
            res_d.ok = !dup_q;
            if (!dup_q && !at_limit) begin
              fill_d = fill_q + 1'b1;
            end
          end
          OP_FWD: begin
            if (fill_q != '0) begin
              res_d.ok              = 1'b1;
              res_d.out_source      = head.source;
              res_d.out_destination = head.destination;
              res_d.out_timestamp   = head.timestamp;
              fill_d                = fill_q - 1'b1;
            end
          end
          OP_COUNT: begin
            res_d.match_count = CNT_W'(cnt_q);
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      step_q  <= '0;
      cnt_q   <= '0;
      dup_q   <= 1'b0;
      done_q  <= 1'b0;
      lim_q   <= LIM_RESET;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      dup_q   <= dup_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        lim_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(DEPTH))
    else $error("fill level above depth");

  a_done_after_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_FINISH))
    else $error("strobe without finish");

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_fwd_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && req_q.op == OP_FWD && fill_q != '0) |=>
      (fill_q == $past(fill_q) - 1'b1))
    else $error("forward did not pop");

endmodule

FILE: rtl/dpf_cell.sv
module dpf_cell
  import dpf_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      at_last_i,
  input  logic      at_tail_i,
  input  entry_t    next_i,
  input  entry_t    head_i,
  input  entry_t    wr_i,
  output entry_t    entry_o
);

  entry_t entry_q;
  entry_t entry_d;
  logic   wr_sel;

  assign wr_sel = ctl_i.evict ? at_last_i : at_tail_i;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.write && wr_sel) begin
      entry_d = wr_i;
    end else if (ctl_i.rotate) begin
      entry_d = at_last_i ? head_i : next_i;
    end else if (ctl_i.shift) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
